FILE: design/assert_macros.svh
// concurrent assertion helpers, sampled on the rising edge, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// condition implies consequence in the next cycle
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

FILE: design/isim_pkg.sv
`default_nettype none
package isim_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int VALUE_W       = 16;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int STATUS_W      = 3;
    localparam int OUT_FIELDS_W  = 2 * VALUE_W + CNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TDATA_W    = ((VALUE_W + 7) / 8) * 8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_DUMP     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_DUMP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch request and per-cell compare flags
        logic apply;      // commit insert, load result
        logic dump_emit;  // load one dump entry, rotate table
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // result register can take a new item
        logic dump_last;  // current dump entry is the final one
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: design/isim_ctrl.sv
`default_nettype none
module isim_ctrl
    import isim_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_req_type,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_req_type == REQ_DUMP) ? S_DUMP : S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.dump_emit = 1'b1;
                    if (i_sts.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/isim_dp.sv
`default_nettype none
`include "assert_macros.svh"
module isim_dp
    import isim_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [VALUE_W-1:0] i_value,
    output t_dp_sts                 o_sts,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [VALUE_W-1:0]      o_range_low,
    output logic [VALUE_W-1:0]      o_range_high,
    output logic [CNT_W-1:0]        o_interval_count,
    output logic [STATUS_W-1:0]     o_status,
    output logic                    o_last
);

    // interval cells
    logic [VALUE_W-1:0] r_low  [MAX_INTERVALS];
    logic [VALUE_W-1:0] r_high [MAX_INTERVALS];
    logic [VALUE_W-1:0] n_low  [MAX_INTERVALS];
    logic [VALUE_W-1:0] n_high [MAX_INTERVALS];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_left;

    // per-cell compare flags, captured at accept
    logic [MAX_INTERVALS-1:0] r_hit, r_adjl, r_adjr, r_gt;
    logic [MAX_INTERVALS-1:0] c_hit, c_adjl, c_adjr, c_gt;
    logic [MAX_INTERVALS-1:0] gt_prev;
    logic [VALUE_W-1:0]       r_v;

    // neighbor views of the cell row
    logic [VALUE_W-1:0] nxt_low  [MAX_INTERVALS];
    logic [VALUE_W-1:0] nxt_high [MAX_INTERVALS];
    logic [VALUE_W-1:0] prv_low  [MAX_INTERVALS];
    logic [VALUE_W-1:0] prv_high [MAX_INTERVALS];

    logic [VALUE_W-1:0] hit_low, hit_high, l_low, r_high_sel;
    logic               any_hit, any_l, any_r;

    // result register
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_o_low, r_o_high;
    logic [CNT_W-1:0]    r_o_count;
    t_status             r_o_status;
    logic                r_o_last;
    logic [VALUE_W-1:0]  n_o_low, n_o_high;
    logic [CNT_W-1:0]    n_o_count;
    t_status             n_o_status;
    logic                n_o_last;
    logic                load_out;

    // parallel compare against every held interval
    always_comb begin
        for (int k = 0; k < MAX_INTERVALS; k++) begin
            logic vld;
            vld       = (CNT_W'(k) < r_count);
            c_hit[k]  = vld && (r_low[k] <= i_value) && (i_value <= r_high[k]);
            c_adjl[k] = vld && (({1'b0, r_high[k]} + 1'b1) == {1'b0, i_value});
            c_adjr[k] = vld && ({1'b0, r_low[k]} == ({1'b0, i_value} + 1'b1));
            c_gt[k]   = vld && (r_low[k] > i_value);
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_INTERVALS - 1; k++) begin
            nxt_low[k]  = r_low[k+1];
            nxt_high[k] = r_high[k+1];
        end
        nxt_low[MAX_INTERVALS-1]  = r_low[MAX_INTERVALS-1];
        nxt_high[MAX_INTERVALS-1] = r_high[MAX_INTERVALS-1];
        prv_low[0]  = r_low[0];
        prv_high[0] = r_high[0];
        for (int k = 1; k < MAX_INTERVALS; k++) begin
            prv_low[k]  = r_low[k-1];
            prv_high[k] = r_high[k-1];
        end
    end

    assign gt_prev = {r_gt[MAX_INTERVALS-2:0], 1'b0};

    // one-hot select of the flagged cells
    always_comb begin
        hit_low    = '0;
        hit_high   = '0;
        l_low      = '0;
        r_high_sel = '0;
        for (int k = 0; k < MAX_INTERVALS; k++) begin
            hit_low    = hit_low    | (r_low[k]  & {VALUE_W{r_hit[k]}});
            hit_high   = hit_high   | (r_high[k] & {VALUE_W{r_hit[k]}});
            l_low      = l_low      | (r_low[k]  & {VALUE_W{r_adjl[k]}});
            r_high_sel = r_high_sel | (r_high[k] & {VALUE_W{r_adjr[k]}});
        end
    end

    assign any_hit = |r_hit;
    assign any_l   = |r_adjl;
    assign any_r   = |r_adjr;

    // table update and result
    always_comb begin
        n_low      = r_low;
        n_high     = r_high;
        n_count    = r_count;
        n_o_low    = '0;
        n_o_high   = '0;
        n_o_count  = r_count;
        n_o_status = ST_INSERTED;
        n_o_last   = 1'b1;
        load_out   = 1'b0;
        if (i_cmd.apply) begin
            load_out = 1'b1;
            if (any_hit) begin
                n_o_low    = hit_low;
                n_o_high   = hit_high;
                n_o_status = ST_PRESENT;
            end else if (any_l && any_r) begin
                // bridge: left cell takes the right end, upper cells move down
                for (int k = 0; k < MAX_INTERVALS; k++) begin
                    if (r_adjl[k]) begin
                        n_high[k] = nxt_high[k];
                    end
                    if (r_gt[k]) begin
                        n_low[k]  = nxt_low[k];
                        n_high[k] = nxt_high[k];
                    end
                end
                n_count  = r_count - CNT_W'(1);
                n_o_low  = l_low;
                n_o_high = r_high_sel;
            end else if (any_l) begin
                for (int k = 0; k < MAX_INTERVALS; k++) begin
                    if (r_adjl[k]) begin
                        n_high[k] = r_v;
                    end
                end
                n_o_low  = l_low;
                n_o_high = r_v;
            end else if (any_r) begin
                for (int k = 0; k < MAX_INTERVALS; k++) begin
                    if (r_adjr[k]) begin
                        n_low[k] = r_v;
                    end
                end
                n_o_low  = r_v;
                n_o_high = r_high_sel;
            end else if (r_count == CNT_W'(MAX_INTERVALS)) begin
                n_o_status = ST_FULL;
            end else begin
                // open a new interval, upper cells move up
                for (int k = 0; k < MAX_INTERVALS; k++) begin
                    if (r_gt[k] || (CNT_W'(k) == r_count)) begin
                        n_low[k]  = gt_prev[k] ? prv_low[k]  : r_v;
                        n_high[k] = gt_prev[k] ? prv_high[k] : r_v;
                    end
                end
                n_count  = r_count + CNT_W'(1);
                n_o_low  = r_v;
                n_o_high = r_v;
            end
            n_o_count = n_count;
        end else if (i_cmd.dump_emit) begin
            load_out = 1'b1;
            if (r_count == '0) begin
                n_o_status = ST_EMPTY;
            end else begin
                n_o_low    = r_low[0];
                n_o_high   = r_high[0];
                n_o_status = ST_DUMP;
                n_o_last   = (r_left == CNT_W'(1));
                // rotate the held cells by one; n steps restore the order
                for (int k = 0; k < MAX_INTERVALS; k++) begin
                    if (CNT_W'(k) == r_count - CNT_W'(1)) begin
                        n_low[k]  = r_low[0];
                        n_high[k] = r_high[0];
                    end else if (CNT_W'(k) < r_count) begin
                        n_low[k]  = nxt_low[k];
                        n_high[k] = nxt_high[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low  <= n_low;
        r_high <= n_high;
        if (i_cmd.capture) begin
            r_v    <= i_value;
            r_left <= r_count;
        end else if (i_cmd.dump_emit) begin
            r_left <= r_left - CNT_W'(1);
        end
        if (load_out) begin
            r_o_low    <= n_o_low;
            r_o_high   <= n_o_high;
            r_o_count  <= n_o_count;
            r_o_status <= n_o_status;
            r_o_last   <= n_o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= '0;
            r_adjl      <= '0;
            r_adjr      <= '0;
            r_gt        <= '0;
        end else begin
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.capture) begin
                r_hit  <= c_hit;
                r_adjl <= c_adjl;
                r_adjr <= c_adjr;
                r_gt   <= c_gt;
            end
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.dump_last = (r_count == '0) || (r_left == CNT_W'(1));

    assign o_out_valid      = r_out_valid;
    assign o_range_low      = r_o_low;
    assign o_range_high     = r_o_high;
    assign o_interval_count = r_o_count;
    assign o_status         = r_o_status;
    assign o_last           = r_o_last;

    `AST_SAME(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_INTERVALS))
    `AST_SAME(a_hit_single, i_clk, i_rst_n, 1'b1, $onehot0(r_hit) && $onehot0(r_adjl))
    `AST_SAME(a_hit_no_adj, i_clk, i_rst_n, any_hit, !any_l && !any_r)
    `AST_NEXT(a_apply_out, i_clk, i_rst_n, i_cmd.apply || i_cmd.dump_emit, r_out_valid)

endmodule
`default_nettype wire

FILE: design/interval_set_insert_merge.sv
// channel  dir  tdata (low bit first)                         tuser        tlast
// s_axis   in   value[15:0]                                   req_type[0]  -
// m_axis   out  range_low[15:0] range_high[31:16]             status[2:0]  last
//               interval_count[37:32], zero pad[39:38]
//
// insert: accept, then a commit step once the result register is free; every held interval
//   is compared with the value in parallel at accept, the commit updates or shifts the cells
// dump: accept, then n entries for n held intervals (one empty entry when the set is empty),
//   one entry per cycle while the result register is free, read from cell 0 while the row rotates
// reset clears the interval count and the handshake state; no clearing pass
// a stalled result stays in the output register; the next item is accepted
//   while it waits, and the commit waits until the register frees up
`default_nettype none
module interval_set_insert_merge
    import isim_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value
    input  wire logic                   s_axis_tuser,   // req_type
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // range_low, range_high, interval_count
    output logic [STATUS_W-1:0]         m_axis_tuser,   // status
    output logic                        m_axis_tlast    // last
);

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [VALUE_W-1:0] range_low, range_high;
    logic [CNT_W-1:0]   interval_count;

    // sequencing of accept, commit and dump steps
    isim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // interval cells, compare flags and result register
    isim_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_value          (s_axis_tdata[VALUE_W-1:0]),
        .o_sts            (sts),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_range_low      (range_low),
        .o_range_high     (range_high),
        .o_interval_count (interval_count),
        .o_status         (m_axis_tuser),
        .o_last           (m_axis_tlast)
    );

    // pack result fields, low field first, zero pad to whole bytes
    assign m_axis_tdata = OUT_TDATA_W'({interval_count, range_high, range_low});

endmodule
`default_nettype wire

FILE: tb/interval_set_monitor.sv
module interval_set_monitor
    import isim_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_req_valid,
    input  wire logic                   i_req_ready,
    input  wire logic [IN_TDATA_W-1:0]  i_req_data,    // value
    input  wire logic                   i_req_kind,    // req_type
    input  wire logic                   i_res_valid,
    input  wire logic                   i_res_ready,
    input  wire logic [OUT_TDATA_W-1:0] i_res_data,    // range_low, range_high, interval_count
    input  wire logic [STATUS_W-1:0]    i_res_status,  // status
    input  wire logic                   i_res_last,    // last
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results_seen,
    output int                          o_full_seen
);

    typedef struct packed {
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [CNT_W-1:0]   cnt;
        t_status            st;
        logic               last;
    } t_range_item;

    logic [VALUE_W-1:0] set_lo [MAX_INTERVALS];
    logic [VALUE_W-1:0] set_hi [MAX_INTERVALS];
    int                 set_used;
    t_range_item        expected_ranges [$];

    task automatic note_range(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                              input t_status st, input logic last);
        t_range_item item;
        item.lo   = lo;
        item.hi   = hi;
        item.cnt  = CNT_W'(set_used);
        item.st   = st;
        item.last = last;
        expected_ranges = {expected_ranges, item};
    endtask

    task automatic add_value(input logic [VALUE_W-1:0] v);
        int   pos;
        int   j;
        logic joins_prev;
        logic joins_next;
        pos        = 0;
        joins_prev = 1'b0;
        joins_next = 1'b0;
        while (pos < set_used && set_lo[pos] <= v) pos++;
        // adjacency is checked one bit wider so the top value never wraps to zero
        if (pos > 0)
            joins_prev = ({1'b0, set_hi[pos-1]} + 1'b1) == {1'b0, v};
        if (pos < set_used)
            joins_next = {1'b0, set_lo[pos]} == ({1'b0, v} + 1'b1);
        if (pos > 0 && set_hi[pos-1] >= v) begin
            note_range(set_lo[pos-1], set_hi[pos-1], ST_PRESENT, 1'b1);
        end else if (joins_prev && joins_next) begin
            set_hi[pos-1] = set_hi[pos];
            for (j = pos; j + 1 < set_used; j++) begin
                set_lo[j] = set_lo[j+1];
                set_hi[j] = set_hi[j+1];
            end
            set_used--;
            note_range(set_lo[pos-1], set_hi[pos-1], ST_INSERTED, 1'b1);
        end else if (joins_prev) begin
            set_hi[pos-1] = v;
            note_range(set_lo[pos-1], set_hi[pos-1], ST_INSERTED, 1'b1);
        end else if (joins_next) begin
            set_lo[pos] = v;
            note_range(set_lo[pos], set_hi[pos], ST_INSERTED, 1'b1);
        end else if (set_used >= MAX_INTERVALS) begin
            o_full_seen++;
            note_range('0, '0, ST_FULL, 1'b1);
        end else begin
            for (j = set_used; j > pos; j--) begin
                set_lo[j] = set_lo[j-1];
                set_hi[j] = set_hi[j-1];
            end
            set_lo[pos] = v;
            set_hi[pos] = v;
            set_used++;
            note_range(v, v, ST_INSERTED, 1'b1);
        end
    endtask

    task automatic list_intervals();
        int k;
        if (set_used == 0) begin
            note_range('0, '0, ST_EMPTY, 1'b1);
        end else begin
            for (k = 0; k < set_used; k++)
                note_range(set_lo[k], set_hi[k], ST_DUMP, k + 1 == set_used);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_range_item got;
        t_range_item want;
        string       bad;
        if (!i_rst_n) begin
            set_used = 0;
            expected_ranges.delete();
            o_pending = 0;
        end else begin
            // results first: nothing accepted at this edge can already be on the output
            if (i_res_valid && i_res_ready) begin
                got.lo   = i_res_data[VALUE_W-1:0];
                got.hi   = i_res_data[2*VALUE_W-1:VALUE_W];
                got.cnt  = i_res_data[2*VALUE_W+CNT_W-1:2*VALUE_W];
                got.st   = t_status'(i_res_status);
                got.last = i_res_last;
                o_results_seen++;
                if (expected_ranges.size() == 0) begin
                    $display("%0t unexpected result: lo=%0d hi=%0d count=%0d status=%0d last=%0d",
                             $time, got.lo, got.hi, got.cnt, got.st, got.last);
                    o_fail_count++;
                end else begin
                    want = expected_ranges.pop_front();
                    bad  = "";
                    if (got.lo !== want.lo)     bad = {bad, " range_low"};
                    if (got.hi !== want.hi)     bad = {bad, " range_high"};
                    if (got.cnt !== want.cnt)   bad = {bad, " interval_count"};
                    if (got.st !== want.st)     bad = {bad, " status"};
                    if (got.last !== want.last) bad = {bad, " last"};
                    if (bad != "") begin
                        $display("%0t mismatch in%s: expected lo=%0d hi=%0d cnt=%0d st=%0d last=%0d",
                                 $time, bad, want.lo, want.hi, want.cnt, want.st, want.last);
                        $display("%0t   actual lo=%0d hi=%0d cnt=%0d st=%0d last=%0d",
                                 $time, got.lo, got.hi, got.cnt, got.st, got.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_kind == REQ_DUMP)
                    list_intervals();
                else
                    add_value(i_req_data[VALUE_W-1:0]);
            end
            o_pending = expected_ranges.size();
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import isim_pkg::*;

    // run sizing
    localparam int RANDOM_ITEMS = 350;
    localparam int IDLE_PCT     = 15;
    localparam int CALM_FIRST   = 150;     // random items in this window never idle
    localparam int CALM_LAST    = 230;
    localparam int CLUSTER_SPAN = 96;      // narrow value window so merges happen often
    localparam int DRAIN_CYCLES = 48;      // settle time after the last expected result is seen
    localparam int CYCLE_LIMIT  = 400000;

    // clock and reset
    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;

    // request side, known from time zero
    logic                   s_axis_tvalid = 1'b0;
    wire logic              s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;    // value[15:0]
    logic                   s_axis_tuser  = 1'b0;  // req_type[0]

    // result side
    wire logic              m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire logic [OUT_TDATA_W-1:0] m_axis_tdata;     // range_low, range_high, interval_count, pad
    wire logic [STATUS_W-1:0]    m_axis_tuser;     // status[2:0]
    wire logic              m_axis_tlast;          // last

    // checker feedback
    int fail_count;
    int pending;
    int results_seen;
    int full_seen;

    // stimulus bookkeeping
    int sent_items  = 0;
    int dump_items  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;   // both sides stop idling while set

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    interval_set_insert_merge u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    interval_set_monitor u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_axis_tvalid),
        .i_req_ready    (s_axis_tready),
        .i_req_data     (s_axis_tdata),
        .i_req_kind     (s_axis_tuser),
        .i_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .i_res_data     (m_axis_tdata),
        .i_res_status   (m_axis_tuser),
        .i_res_last     (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_full_seen    (full_seen)
    );

    // result sink: random back-pressure, none in the calm window
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // one request item; returns at the edge where it is taken
    task automatic push_request(input logic req, input logic [VALUE_W-1:0] val);
        // optional idle cycles before presenting the item
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(val);
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_items++;
        if (req == REQ_DUMP) dump_items++;
    endtask

    // insert with a value drawn from one of the shapes the random part uses
    task automatic push_random_insert(input int cluster_base);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            push_request(REQ_INSERT, VALUE_W'(cluster_base + $urandom_range(0, CLUSTER_SPAN - 1)));
        else if (pick < 90)
            push_request(REQ_INSERT, VALUE_W'($urandom));
        else begin
            // range ends and their neighbors
            case ($urandom_range(0, 3))
                0:       push_request(REQ_INSERT, '0);
                1:       push_request(REQ_INSERT, '1);
                2:       push_request(REQ_INSERT, VALUE_W'(1));
                default: push_request(REQ_INSERT, VALUE_W'({VALUE_W{1'b1}} - 1));
            endcase
        end
    endtask

    // timeout guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int n;
        int cluster_base;
        cluster_base = 0;

        // reset asserted from time zero, released once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, zero, top of range, extend both ways, bridge, repeats
        push_request(REQ_DUMP,   16'h1234);   // dump of an empty set, value ignored
        push_request(REQ_INSERT, 16'd0);      // zero opens an interval at the bottom
        push_request(REQ_INSERT, 16'd1);      // extend upward
        push_request(REQ_INSERT, 16'hFFFF);   // top value, must not join 0
        push_request(REQ_INSERT, 16'hFFFE);   // extend downward onto the top interval
        push_request(REQ_INSERT, 16'd3);      // fresh single value
        push_request(REQ_INSERT, 16'd2);      // bridge 0..1 and 3
        push_request(REQ_INSERT, 16'd2);      // already covered
        push_request(REQ_INSERT, 16'd0);      // covered at the low end
        push_request(REQ_INSERT, 16'hFFFF);   // covered at the top end
        push_request(REQ_INSERT, 16'd100);
        push_request(REQ_INSERT, 16'd98);
        push_request(REQ_INSERT, 16'd99);     // bridge 98 and 100
        push_request(REQ_INSERT, 16'h8000);
        push_request(REQ_INSERT, 16'h5555);
        push_request(REQ_INSERT, 16'hAAAA);
        push_request(REQ_INSERT, 16'd5);
        push_request(REQ_INSERT, 16'd4);      // bridge 0..3 and 5
        push_request(REQ_INSERT, 16'h7FFF);   // joins 0x8000 from below
        push_request(REQ_DUMP,   16'hFFFF);

        // random: wide values fill the table, clustered ones extend and merge
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (n % 40 == 0)
                cluster_base = $urandom_range(0, (1 << VALUE_W) - CLUSTER_SPAN);
            if ($urandom_range(0, 99) < 10)
                push_request(REQ_DUMP, VALUE_W'($urandom));
            else
                push_random_insert(cluster_base);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // drain: wait for every expected result, then let the pipeline settle
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d dumps), %0d result items compared",
                 sent_items, dump_items, results_seen);
        $display("full-table refusals predicted %0d times, %0d failures, %0d left waiting",
                 full_seen, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/isim_pkg.sv
design/isim_ctrl.sv
design/isim_dp.sv
design/interval_set_insert_merge.sv
tb/interval_set_monitor.sv
tb/testbench.sv
